/* rtl/core/voqsf_pkg.sv */
package voqsf_pkg;

   // operation codes of an input transaction
   localparam logic [1:0] OP_START_FLOW = 2'd0;
   localparam logic [1:0] OP_ACCEPT     = 2'd1;
   localparam logic [1:0] OP_TRANSMIT   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_DELIVERED = 2'd1;
   localparam logic [1:0] KIND_SENT      = 2'd2;

   // register indexes of the csr port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_INDEX   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODES_IN_USE = 1'd1;

   localparam int NODE_ID_W = 4;
   localparam int FLOW_W    = 16;
   localparam int SEQ_W     = 12;
   localparam int TOTAL_W   = 32;
   // wide enough for a node count up to 64 and the 5-bit register
   localparam int CMP_W     = 7;

   typedef struct packed {
      logic [1:0]           op;
      logic [NODE_ID_W-1:0] src_node;
      logic [NODE_ID_W-1:0] dst_node;
      logic [FLOW_W-1:0]    flow_ident;
      logic [SEQ_W-1:0]     sequence_number;
      logic [SEQ_W-1:0]     flow_packets;
      logic [NODE_ID_W-1:0] slot_target;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]           out_kind;
      logic [NODE_ID_W-1:0] out_source;
      logic [NODE_ID_W-1:0] out_target;
      logic [FLOW_W-1:0]    out_flow;
      logic [SEQ_W-1:0]     out_sequence;
      logic [TOTAL_W-1:0]   sent_total;
      logic [TOTAL_W-1:0]   dropped_total;
   } rsp_payload_type;

   // one stored packet, 36 bits
   typedef struct packed {
      logic [NODE_ID_W-1:0] src;
      logic [NODE_ID_W-1:0] tgt;
      logic [FLOW_W-1:0]    flow;
      logic [SEQ_W-1:0]     seq;
   } packet_type;

endpackage

/* rtl/core/voqsf_if.sv */
interface voqsf_req_if;
   logic                      valid;
   logic                      ready;
   voqsf_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface voqsf_rsp_if;
   logic                      valid;
   logic                      ready;
   voqsf_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/voq_spray_forwarder_core.sv */
// sequence: a delivery, a drop or op 3 goes from idle straight to the done state; a queued packet
// passes the enqueue state, a transmit tick the transmit state and, for a non-empty queue, tx-out
// flow start: the modulo state, then a flow and an enqueue step per packet plus a flow step per
// skipped local node; the spray walks one descriptor read and write-back per packet
// one transaction at a time; a new one is taken once the result is in the output register
// reset: synchronous, queues empty at once through descriptor valid bits, no clearing pass
module voq_spray_forwarder_core #(
   parameter int MAX_NODES        = 16,
   parameter int QUEUE_DEPTH      = 16,
   parameter int MAX_FLOW_PACKETS = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   voqsf_req_if.sink                              req_chan,
   voqsf_rsp_if.source                            rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [voqsf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [voqsf_pkg::CSR_DATA_W-1:0]       csr_data
);
   import voqsf_pkg::*;

   localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int DESC_W = 2 * SLOT_W + FILL_W;
   localparam int ADDR_W = NODE_W + SLOT_W;
   localparam logic [CMP_W-1:0]  NODE_CAP  = CMP_W'(MAX_NODES);
   localparam logic [SLOT_W:0]   SLOT_END  = (SLOT_W + 1)'(QUEUE_DEPTH);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
   localparam logic [16:0]       FLOW_CAP  = 17'(MAX_FLOW_PACKETS);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MOD   = 7'b0000010,
      ST_FLOW  = 7'b0000100,
      ST_ENQ   = 7'b0001000,
      ST_TX    = 7'b0010000,
      ST_TXOUT = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic              is_flow_ff, is_flow_in;
   logic [CMP_W-1:0]  mod_ff, mod_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [SEQ_W-1:0]  k_ff, k_in;
   logic [SEQ_W-1:0]  limit_ff, limit_in;
   logic [NODE_W-1:0] q_ff, q_in;
   packet_type        pkt_ff, pkt_in;
   rsp_payload_type   res_ff, res_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] sent_ff, sent_in;
   logic [TOTAL_W-1:0] drop_ff, drop_in;
   logic [NODE_ID_W-1:0] node_index_ff, node_index_in;
   logic [4:0]        nodes_in_use_ff, nodes_in_use_in;

   logic              desc_rd_en, desc_wr_en;
   logic [NODE_W-1:0] desc_rd_addr, desc_wr_addr;
   logic [DESC_W-1:0] desc_rd_data, desc_wr_data;
   logic              pkt_rd_en, pkt_wr_en;
   logic [ADDR_W-1:0] pkt_rd_addr, pkt_wr_addr;
   packet_type        pkt_rd_data, pkt_wr_data;

   logic [SLOT_W-1:0] rd_head, rd_tail, head_next, tail_next;
   logic [FILL_W-1:0] rd_fill;
   logic [SLOT_W:0]   head_inc, tail_inc;
   logic [CMP_W-1:0]  niu_w, n_eff, cur_inc;
   logic [NODE_W-1:0] cur_next;
   logic              out_free;
   req_payload_type   req;

   voqsf_desc_mem #(
      .DEPTH  (MAX_NODES),
      .DATA_W (DESC_W)
   ) u_desc_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (desc_rd_en),
      .rd_addr (desc_rd_addr),
      .rd_data (desc_rd_data),
      .wr_en   (desc_wr_en),
      .wr_addr (desc_wr_addr),
      .wr_data (desc_wr_data)
   );

   voqsf_pkt_mem #(
      .ADDR_W (ADDR_W)
   ) u_pkt_mem (
      .clock   (clock),
      .rd_en   (pkt_rd_en),
      .rd_addr (pkt_rd_addr),
      .rd_data (pkt_rd_data),
      .wr_en   (pkt_wr_en),
      .wr_addr (pkt_wr_addr),
      .wr_data (pkt_wr_data)
   );

   assign req      = req_chan.payload;
   assign rd_head  = desc_rd_data[DESC_W-1 -: SLOT_W];
   assign rd_tail  = desc_rd_data[SLOT_W+FILL_W-1 -: SLOT_W];
   assign rd_fill  = desc_rd_data[FILL_W-1:0];
   assign head_inc = {1'b0, rd_head} + 1'b1;
   assign tail_inc = {1'b0, rd_tail} + 1'b1;
   assign head_next = (head_inc >= SLOT_END) ? '0 : head_inc[SLOT_W-1:0];
   assign tail_next = (tail_inc >= SLOT_END) ? '0 : tail_inc[SLOT_W-1:0];

   // node count clamped to the range the fabric supports
   assign niu_w    = CMP_W'(nodes_in_use_ff);
   assign n_eff    = (niu_w < CMP_W'(2)) ? CMP_W'(2) : ((niu_w > NODE_CAP) ? NODE_CAP : niu_w);
   assign cur_inc  = CMP_W'(cur_ff) + 1'b1;
   assign cur_next = (cur_inc >= n_eff) ? '0 : NODE_W'(cur_inc);

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      is_flow_in   = is_flow_ff;
      mod_in       = mod_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      limit_in     = limit_ff;
      q_in         = q_ff;
      pkt_in       = pkt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      sent_in      = sent_ff;
      drop_in      = drop_ff;
      desc_rd_en   = 1'b0;
      desc_rd_addr = q_ff;
      desc_wr_en   = 1'b0;
      desc_wr_addr = q_ff;
      desc_wr_data = {rd_head, rd_tail, rd_fill};
      pkt_rd_en    = 1'b0;
      pkt_rd_addr  = {q_ff, rd_head};
      pkt_wr_en    = 1'b0;
      pkt_wr_addr  = {q_ff, rd_tail};
      pkt_wr_data  = pkt_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               res_in      = '0;
               res_in.out_kind = KIND_NONE;
               is_flow_in  = 1'b0;
               pkt_in.src  = req.src_node;
               pkt_in.tgt  = req.dst_node;
               pkt_in.flow = req.flow_ident;
               pkt_in.seq  = req.sequence_number;
               state_in    = ST_DONE;
               case (req.op)
                  OP_START_FLOW: begin
                     is_flow_in = 1'b1;
                     mod_in     = CMP_W'(req.dst_node);
                     k_in       = '0;
                     limit_in   = (17'(req.flow_packets) > FLOW_CAP) ? FLOW_CAP[SEQ_W-1:0]
                                                                     : req.flow_packets;
                     state_in   = ST_MOD;
                  end
                  OP_ACCEPT: begin
                     if (req.dst_node == node_index_ff) begin
                        res_in.out_kind     = KIND_DELIVERED;
                        res_in.out_source   = req.src_node;
                        res_in.out_target   = req.dst_node;
                        res_in.out_flow     = req.flow_ident;
                        res_in.out_sequence = req.sequence_number;
                     end else if (CMP_W'(req.dst_node) >= NODE_CAP) begin
                        drop_in = drop_ff + 1'b1;
                     end else begin
                        q_in         = NODE_W'(req.dst_node);
                        desc_rd_en   = 1'b1;
                        desc_rd_addr = NODE_W'(req.dst_node);
                        state_in     = ST_ENQ;
                     end
                  end
                  OP_TRANSMIT: begin
                     if (CMP_W'(req.slot_target) < NODE_CAP) begin
                        q_in         = NODE_W'(req.slot_target);
                        desc_rd_en   = 1'b1;
                        desc_rd_addr = NODE_W'(req.slot_target);
                        state_in     = ST_TX;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // target modulo node count, one subtraction a cycle
         ST_MOD: begin
            if (mod_ff >= n_eff) begin
               mod_in = mod_ff - n_eff;
            end else begin
               cur_in   = NODE_W'(mod_ff);
               state_in = ST_FLOW;
            end
         end
         ST_FLOW: begin
            if (k_ff == limit_ff) begin
               state_in = ST_DONE;
            end else if (CMP_W'(cur_ff) == CMP_W'(node_index_ff)) begin
               cur_in = cur_next;
            end else begin
               q_in         = cur_ff;
               pkt_in.seq   = k_ff;
               desc_rd_en   = 1'b1;
               desc_rd_addr = cur_ff;
               state_in     = ST_ENQ;
            end
         end
         ST_ENQ: begin
            if (rd_fill >= FILL_FULL) begin
               drop_in = drop_ff + 1'b1;
            end else begin
               pkt_wr_en    = 1'b1;
               desc_wr_en   = 1'b1;
               desc_wr_data = {rd_head, tail_next, rd_fill + 1'b1};
            end
            if (is_flow_ff) begin
               k_in     = k_ff + 1'b1;
               cur_in   = cur_next;
               state_in = ST_FLOW;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TX: begin
            if (rd_fill != '0) begin
               pkt_rd_en    = 1'b1;
               desc_wr_en   = 1'b1;
               desc_wr_data = {head_next, rd_tail, rd_fill - 1'b1};
               sent_in      = sent_ff + 1'b1;
               state_in     = ST_TXOUT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TXOUT: begin
            res_in.out_kind     = KIND_SENT;
            res_in.out_source   = pkt_rd_data.src;
            res_in.out_target   = pkt_rd_data.tgt;
            res_in.out_flow     = pkt_rd_data.flow;
            res_in.out_sequence = pkt_rd_data.seq;
            state_in            = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in               = res_ff;
               rsp_in.sent_total    = sent_ff;
               rsp_in.dropped_total = drop_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      node_index_in   = node_index_ff;
      nodes_in_use_in = nodes_in_use_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NODE_INDEX:   node_index_in   = csr_data[NODE_ID_W-1:0];
            CSR_NODES_IN_USE: nodes_in_use_in = csr_data;
            default: begin
               node_index_in = node_index_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         sent_ff         <= '0;
         drop_ff         <= '0;
         node_index_ff   <= '0;
         nodes_in_use_ff <= 5'd16;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         sent_ff         <= sent_in;
         drop_ff         <= drop_in;
         node_index_ff   <= node_index_in;
         nodes_in_use_ff <= nodes_in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      is_flow_ff <= is_flow_in;
      mod_ff     <= mod_in;
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      limit_ff   <= limit_in;
      q_ff       <= q_in;
      pkt_ff     <= pkt_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end
endmodule

/* rtl/core/voqsf_desc_mem.sv */
module voqsf_desc_mem #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an entry never written reads as an empty queue
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;
endmodule

/* rtl/core/voqsf_pkt_mem.sv */
module voqsf_pkt_mem #(
   parameter int ADDR_W = 8
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output voqsf_pkg::packet_type rd_data,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  voqsf_pkg::packet_type wr_data
);
   import voqsf_pkg::*;

   packet_type mem_ff [2**ADDR_W];
   packet_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
